@@ src/imaenc_pkg.sv @@
// imaenc_pkg: step size table, index adjustment table and limits for the
// ima adpcm nibble encoder. no dependencies.
`default_nettype none

package imaenc_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int POS_W      = 7;
   localparam int CODE_W     = 4;
   localparam int BYTE_W     = 8;
   localparam int MOVE_W     = 5;

   localparam logic [POS_W-1:0] STEP_POS_MAX = 7'd88;

   localparam logic signed [SAMPLE_W+1:0] PRED_HI = 18'sd32767;
   localparam logic signed [SAMPLE_W+1:0] PRED_LO = -18'sd32768;

   function automatic logic [SAMPLE_W-1:0] step_size(input logic [POS_W-1:0] pos);
      logic [SAMPLE_W-1:0] s;
      begin
         case (pos)
            7'd0:  s = 16'd7;     7'd1:  s = 16'd8;     7'd2:  s = 16'd9;
            7'd3:  s = 16'd10;    7'd4:  s = 16'd11;    7'd5:  s = 16'd12;
            7'd6:  s = 16'd13;    7'd7:  s = 16'd14;    7'd8:  s = 16'd16;
            7'd9:  s = 16'd17;    7'd10: s = 16'd19;    7'd11: s = 16'd21;
            7'd12: s = 16'd23;    7'd13: s = 16'd25;    7'd14: s = 16'd28;
            7'd15: s = 16'd31;    7'd16: s = 16'd34;    7'd17: s = 16'd37;
            7'd18: s = 16'd41;    7'd19: s = 16'd45;    7'd20: s = 16'd50;
            7'd21: s = 16'd55;    7'd22: s = 16'd60;    7'd23: s = 16'd66;
            7'd24: s = 16'd73;    7'd25: s = 16'd80;    7'd26: s = 16'd88;
            7'd27: s = 16'd97;    7'd28: s = 16'd107;   7'd29: s = 16'd118;
            7'd30: s = 16'd130;   7'd31: s = 16'd143;   7'd32: s = 16'd157;
            7'd33: s = 16'd173;   7'd34: s = 16'd190;   7'd35: s = 16'd209;
            7'd36: s = 16'd230;   7'd37: s = 16'd253;   7'd38: s = 16'd279;
            7'd39: s = 16'd307;   7'd40: s = 16'd337;   7'd41: s = 16'd371;
            7'd42: s = 16'd408;   7'd43: s = 16'd449;   7'd44: s = 16'd494;
            7'd45: s = 16'd544;   7'd46: s = 16'd598;   7'd47: s = 16'd658;
            7'd48: s = 16'd724;   7'd49: s = 16'd796;   7'd50: s = 16'd876;
            7'd51: s = 16'd963;   7'd52: s = 16'd1060;  7'd53: s = 16'd1166;
            7'd54: s = 16'd1282;  7'd55: s = 16'd1411;  7'd56: s = 16'd1552;
            7'd57: s = 16'd1707;  7'd58: s = 16'd1878;  7'd59: s = 16'd2066;
            7'd60: s = 16'd2272;  7'd61: s = 16'd2499;  7'd62: s = 16'd2749;
            7'd63: s = 16'd3024;  7'd64: s = 16'd3327;  7'd65: s = 16'd3660;
            7'd66: s = 16'd4026;  7'd67: s = 16'd4428;  7'd68: s = 16'd4871;
            7'd69: s = 16'd5358;  7'd70: s = 16'd5894;  7'd71: s = 16'd6484;
            7'd72: s = 16'd7132;  7'd73: s = 16'd7845;  7'd74: s = 16'd8630;
            7'd75: s = 16'd9493;  7'd76: s = 16'd10442; 7'd77: s = 16'd11487;
            7'd78: s = 16'd12635; 7'd79: s = 16'd13899; 7'd80: s = 16'd15289;
            7'd81: s = 16'd16818; 7'd82: s = 16'd18500; 7'd83: s = 16'd20350;
            7'd84: s = 16'd22385; 7'd85: s = 16'd24623; 7'd86: s = 16'd27086;
            7'd87: s = 16'd29794;
            default: s = 16'd32767;
         endcase
         return s;
      end
   endfunction

   function automatic logic signed [MOVE_W-1:0] index_move(input logic [2:0] mag);
      logic signed [MOVE_W-1:0] m;
      begin
         case (mag)
            3'd4:    m = 5'sd2;
            3'd5:    m = 5'sd4;
            3'd6:    m = 5'sd6;
            3'd7:    m = 5'sd8;
            default: m = -5'sd1;
         endcase
         return m;
      end
   endfunction

endpackage

`default_nettype wire

@@ src/ima_adpcm_nibble_encoder.sv @@
// ima_adpcm_nibble_encoder: top level, 4-bit ima adpcm coder with nibble packing.
// depends on imaenc_pkg.
`default_nettype none

// Takes one 16-bit pcm sample per beat and sustains one sample per clock
// while no byte is stalled at the output. A sample is captured in an input
// register, coded combinationally by a compare-subtract chain against the
// current step size, and its byte lands in the output register. Every
// second sample (or a sample flagged as frame end) yields one byte, earlier
// code in the low nibble. The input register keeps taking beats while a
// byte waits at the output, and stalls only once both hold data. Predictor
// and step index come out of reset at zero; tuser on the input restarts the
// coder, tlast closes the frame.
module ima_adpcm_nibble_encoder (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   input  wire logic [imaenc_pkg::SAMPLE_W-1:0]     req_tdata,  // sample[15:0]
   input  wire logic                                req_tuser,  // restart
   input  wire logic                                req_tlast,  // frame_end
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   output      logic [imaenc_pkg::BYTE_W-1:0]       rsp_tdata,  // code_byte[7:0]
   output      logic                                rsp_tlast   // closes_frame
);
   import imaenc_pkg::*;

   // input register
   logic                       in_valid_ff;
   logic [SAMPLE_W-1:0]        sample_ff;
   logic                       restart_ff;
   logic                       frame_end_ff;

   // coder state
   logic signed [SAMPLE_W-1:0] pred_ff, pred_in;
   logic [POS_W-1:0]           pos_ff, pos_in;
   logic [CODE_W-1:0]          held_ff, held_in;
   logic                       holding_ff, holding_in;

   // output register
   logic                       out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]          out_byte_ff, out_byte_in;
   logic                       out_last_ff, out_last_in;

   logic                       advance;
   logic signed [SAMPLE_W-1:0] pred_cur;
   logic [POS_W-1:0]           pos_cur;
   logic                       holding_cur;
   logic [SAMPLE_W-1:0]        step;
   logic signed [SAMPLE_W:0]   diff;
   logic                       neg;
   logic [SAMPLE_W-1:0]        mag, mag1, mag2;
   logic                       b2, b1, b0;
   logic [SAMPLE_W:0]          delta;
   logic signed [SAMPLE_W+1:0] pred_sum;
   logic [CODE_W-1:0]          code;
   logic signed [POS_W+1:0]    pos_sum;
   logic signed [MOVE_W-1:0]   move;
   logic                       emit;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      pred_cur    = restart_ff ? '0 : pred_ff;
      pos_cur     = restart_ff ? '0 : pos_ff;
      holding_cur = restart_ff ? 1'b0 : holding_ff;

      step = step_size(pos_cur);
      diff = $signed({sample_ff[SAMPLE_W-1], sample_ff})
           - $signed({pred_cur[SAMPLE_W-1], pred_cur});
      neg  = diff[SAMPLE_W];
      mag  = neg ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];

      b2   = (mag >= step);
      mag1 = b2 ? (mag - step) : mag;
      b1   = (mag1 >= (step >> 1));
      mag2 = b1 ? (mag1 - (step >> 1)) : mag1;
      b0   = (mag2 >= (step >> 2));

      delta = (SAMPLE_W+1)'(step >> 3)
            + (b2 ? (SAMPLE_W+1)'(step) : '0)
            + (b1 ? (SAMPLE_W+1)'(step >> 1) : '0)
            + (b0 ? (SAMPLE_W+1)'(step >> 2) : '0);

      pred_sum = neg ? ($signed({{2{pred_cur[SAMPLE_W-1]}}, pred_cur})
                        - $signed({1'b0, delta}))
                     : ($signed({{2{pred_cur[SAMPLE_W-1]}}, pred_cur})
                        + $signed({1'b0, delta}));

      code = {neg, b2, b1, b0};
      move = index_move(code[2:0]);
      pos_sum = $signed({2'b00, pos_cur}) + $signed({{(POS_W+2-MOVE_W){move[MOVE_W-1]}}, move});

      pred_in    = pred_ff;
      pos_in     = pos_ff;
      held_in    = held_ff;
      holding_in = holding_ff;
      emit       = 1'b0;
      out_byte_in = out_byte_ff;
      out_last_in = out_last_ff;

      if (advance) begin
         if (pred_sum > PRED_HI) begin
            pred_in = PRED_HI[SAMPLE_W-1:0];
         end else if (pred_sum < PRED_LO) begin
            pred_in = PRED_LO[SAMPLE_W-1:0];
         end else begin
            pred_in = pred_sum[SAMPLE_W-1:0];
         end

         if (pos_sum < 0) begin
            pos_in = '0;
         end else if (pos_sum > $signed({2'b00, STEP_POS_MAX})) begin
            pos_in = STEP_POS_MAX;
         end else begin
            pos_in = pos_sum[POS_W-1:0];
         end

         if (holding_cur) begin
            emit        = 1'b1;
            out_byte_in = {code, held_ff};
            out_last_in = frame_end_ff;
            held_in     = '0;
            holding_in  = 1'b0;
         end else if (frame_end_ff) begin
            emit        = 1'b1;
            out_byte_in = {{(BYTE_W-CODE_W){1'b0}}, code};
            out_last_in = 1'b1;
            held_in     = '0;
            holding_in  = 1'b0;
         end else begin
            held_in     = code;
            holding_in  = 1'b1;
         end
      end

      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         pred_ff      <= '0;
         pos_ff       <= '0;
         held_ff      <= '0;
         holding_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         pred_ff      <= pred_in;
         pos_ff       <= pos_in;
         held_ff      <= held_in;
         holding_ff   <= holding_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         sample_ff    <= req_tdata;
         restart_ff   <= req_tuser;
         frame_end_ff <= req_tlast;
      end
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

@@ src/imaenc_checker.sv @@
// imaenc_checker: port-level checks for ima_adpcm_nibble_encoder, bound to the top.
// depends on ima_adpcm_nibble_encoder.
`default_nettype none

module imaenc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tvalid,
   input wire logic       req_tready,
   input wire logic       req_tlast,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic       rsp_tlast
);

   // stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp beat changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   // frame end always yields a closing byte via input and output registers when output drains
   a_frame_flush: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) ##1 (rsp_tready || !rsp_tvalid)
      |=> rsp_tvalid && rsp_tlast)
      else $error("frame end produced no closing byte");

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

endmodule

bind ima_adpcm_nibble_encoder imaenc_checker u_imaenc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
